// ===== design/bsfd_pkg.sv =====
// Shared types and constants of the byte-stuffed frame deframer.
`default_nettype none
package bsfd_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam int HOLD_BITS = 24;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_SYNC = 3'd1,
    PH_LMID = 3'd2,
    PH_LLOW = 3'd3,
    PH_BODY = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_EMPTY     = 2'd1,
    KIND_SKIPPED   = 2'd2,
    KIND_MALFORMED = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [7:0]            data;
    logic [HOLD_BITS-1:0]  hold;
    logic                  first;
    logic                  last;
  } record_t;

endpackage
`default_nettype wire

// ===== design/byte_stuffed_frame_deframer.sv =====
// Top level of the byte-stuffed frame deframer.
//
// The input channel (in_valid, in_stall, rx_byte) takes one received byte per
// request. The output channel (out_valid, out_stall and the result fields)
// gives zero or one result per byte: a skipped byte while hunting, a malformed
// length report, an empty-packet report, or one payload byte with first and
// last marks along with the command type and sequence id of its frame.
// A byte is taken every cycle while the output side keeps up. A result is
// written into the two-entry queue at the edge that accepts its byte, then
// moves on to the output register, which raises out_valid when it loads.
// When the receiver stalls, results collect in the queue; the input side
// raises in_stall only once the queue holds two results, so up to three
// results can wait in total. Reset empties the queue and the output
// register and puts the parser back into hunting for a frame start.
`default_nettype none
module byte_stuffed_frame_deframer #(
  parameter int LENGTH_BITS = 24
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    rx_byte,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [1:0]         kind,
  output logic [7:0]         data,
  output logic [15:0]        cmd_type,
  output logic [14:0]        seq_id,
  output logic               first,
  output logic               last
);
  import bsfd_pkg::*;

  logic     accept;
  logic     res_valid;
  record_t  res;
  logic     q_full;
  logic     q_nonempty;
  logic     q_pop;
  record_t  q_head;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  bsfd_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  bsfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept && res_valid),
    .push_rec (res),
    .pop      (q_pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  bsfd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .data       (data),
    .cmd_type   (cmd_type),
    .seq_id     (seq_id),
    .first      (first),
    .last       (last)
  );

endmodule
`default_nettype wire

// ===== design/bsfd_front.sv =====
// Front end: header parsing, unstuffing and classification of each received byte.
`default_nettype none
module bsfd_front #(
  parameter int LENGTH_BITS = 24
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [7:0]       rx_byte,
  output logic                  res_valid,
  output bsfd_pkg::record_t     res
);
  import bsfd_pkg::*;

  phase_t                   phase, phase_next;
  logic                     esc, esc_next;
  logic [LENGTH_BITS-1:0]   len, len_next;
  logic [LENGTH_BITS-1:0]   count, count_next;
  logic [HOLD_BITS-1:0]     hold, hold_next;
  logic [15:0]              hdr, hdr_next;

  logic                     is_ff;
  logic [23:0]              hdr_full;
  logic [LENGTH_BITS-1:0]   hdr_len;
  logic                     len_short;
  logic                     kept;
  logic                     count_lt3;
  logic                     empty_pkt;
  logic                     last_byte;
  logic [LENGTH_BITS:0]     count_inc;

  assign is_ff     = (rx_byte == SYNC_BYTE);
  assign hdr_full  = {hdr, rx_byte};
  assign hdr_len   = hdr_full[LENGTH_BITS-1:0];
  assign len_short = (hdr_len < LENGTH_BITS'(3));
  assign kept      = esc || !is_ff;
  assign count_lt3 = (count < LENGTH_BITS'(3));
  assign empty_pkt = (count == LENGTH_BITS'(2)) && (len == LENGTH_BITS'(3));
  assign count_inc = {1'b0, count} + (LENGTH_BITS+1)'(1);
  assign last_byte = (count_inc >= {1'b0, len});

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      esc   <= 1'b0;
      len   <= '0;
      count <= '0;
      hold  <= '0;
      hdr   <= '0;
    end else if (accept) begin
      phase <= phase_next;
      esc   <= esc_next;
      len   <= len_next;
      count <= count_next;
      hold  <= hold_next;
      hdr   <= hdr_next;
    end
  end

  always_comb begin
    phase_next = phase;
    esc_next   = esc;
    len_next   = len;
    count_next = count;
    hold_next  = hold;
    hdr_next   = hdr;
    case (phase)
      PH_HUNT: begin
        if (is_ff) begin
          phase_next = PH_SYNC;
        end
      end
      PH_SYNC: begin
        if (!is_ff) begin
          hdr_next[15:8] = rx_byte;
          phase_next     = PH_LMID;
        end
      end
      PH_LMID: begin
        hdr_next[7:0] = rx_byte;
        phase_next    = PH_LLOW;
      end
      PH_LLOW: begin
        esc_next   = 1'b0;
        count_next = '0;
        hold_next  = '0;
        if (len_short) begin
          phase_next = PH_HUNT;
          len_next   = '0;
        end else begin
          phase_next = PH_BODY;
          len_next   = hdr_len;
        end
      end
      PH_BODY: begin
        if (!kept) begin
          esc_next = 1'b1;
        end else begin
          esc_next   = 1'b0;
          count_next = count_inc[LENGTH_BITS-1:0];
          if (count_lt3) begin
            hold_next = {hold[HOLD_BITS-9:0], rx_byte};
          end
          if ((count_lt3 && empty_pkt) || (!count_lt3 && last_byte)) begin
            phase_next = PH_HUNT;
            len_next   = '0;
            count_next = '0;
            hold_next  = '0;
          end
        end
      end
      default: begin
        phase_next = PH_HUNT;
        esc_next   = 1'b0;
        len_next   = '0;
        count_next = '0;
        hold_next  = '0;
      end
    endcase
  end

  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    res.kind  = KIND_PAYLOAD;
    case (phase)
      PH_HUNT: begin
        if (!is_ff) begin
          res_valid = 1'b1;
          res.kind  = KIND_SKIPPED;
          res.data  = rx_byte;
        end
      end
      PH_SYNC: begin
        if (is_ff) begin
          res_valid = 1'b1;
          res.kind  = KIND_SKIPPED;
          res.data  = SYNC_BYTE;
        end
      end
      PH_LLOW: begin
        if (len_short) begin
          res_valid = 1'b1;
          res.kind  = KIND_MALFORMED;
        end
      end
      PH_BODY: begin
        if (kept) begin
          if (count_lt3) begin
            if (empty_pkt) begin
              res_valid = 1'b1;
              res.kind  = KIND_EMPTY;
              res.hold  = {hold[HOLD_BITS-9:0], rx_byte};
              res.last  = 1'b1;
            end
          end else begin
            res_valid = 1'b1;
            res.kind  = KIND_PAYLOAD;
            res.data  = rx_byte;
            res.hold  = hold;
            res.first = (count == LENGTH_BITS'(3));
            res.last  = last_byte;
          end
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/bsfd_queue.sv =====
// Two-entry result queue between the front end and the output stage.
`default_nettype none
module bsfd_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire bsfd_pkg::record_t  push_rec,
  input  wire logic               pop,
  output logic                    full,
  output logic                    nonempty,
  output bsfd_pkg::record_t       head
);
  import bsfd_pkg::*;

  record_t      entries [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   fill;

  assign full     = (fill == 2'd2);
  assign nonempty = (fill != 2'd0);
  assign head     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/bsfd_back.sv =====
// Output stage: formats command and sequence fields and holds the result register.
`default_nettype none
module bsfd_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_nonempty,
  input  wire bsfd_pkg::record_t  q_head,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              kind,
  output logic [7:0]              data,
  output logic [15:0]             cmd_type,
  output logic [14:0]             seq_id,
  output logic                    first,
  output logic                    last
);
  import bsfd_pkg::*;

  assign q_pop = q_nonempty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= q_nonempty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind     <= q_head.kind;
      data     <= q_head.data;
      cmd_type <= {q_head.hold[23], 7'd0, q_head.hold[7:0]};
      seq_id   <= {q_head.hold[22:16], q_head.hold[15:8]};
      first    <= q_head.first;
      last     <= q_head.last;
    end
  end

endmodule
`default_nettype wire
